// ----- hdl/sha512_pkg.sv -----
package sha512_pkg;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_EMIT
    } core_state_t;

    localparam logic [60:0] TOTAL_MAX = {61{1'b1}};
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [63:0] INIT_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ----- hdl/sha512_hash_engine_unit.sv -----
// SHA-512 engine. Message words enter through a two-entry request queue that
// drops empty words not ending a message; in_ready falls only while both
// entries are full. The core accepts a request only while idle, then places
// its valid bytes one by one into the 128-byte block. Each full block then
// runs through 80 rounds and a fold into the hash. A last word adds a pad
// marker and zero bytes up to byte 112, then the length goes into the final
// block; when fewer than 17 bytes are left in the block the padding first
// fills it out and costs another compression. The eight digest words follow,
// one per cycle while out_ready is high.
module sha512_hash_engine_unit
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    logic q_valid, q_ready;
    req_t q_data;

    sha512_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .message_word(message_word), .valid_bytes(valid_bytes), .last(last),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    sha512_core u_core (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .out_valid(out_valid), .out_ready(out_ready),
        .digest_word(digest_word), .word_index(word_index), .digest_last(digest_last)
    );

endmodule

// ----- hdl/sha512_front.sv -----
module sha512_front
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        last,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_data
);

    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    req_t       slot_reg [2];
    logic [3:0] n_clip;
    logic       push;

    // clip the byte count and drop empty words that do not end a message
    assign n_clip = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    assign push = valid && ready && (n_clip != 4'd0 || last);
    assign ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = slot_reg[rd_reg];

    // store the request payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= '{word: message_word, nbytes: n_clip, last: last};
    end

    // advance queue pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (q_valid && q_ready)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, (q_valid && q_ready)};
        end
    end

endmodule

// ----- hdl/sha512_core.sv -----
module sha512_core
    import sha512_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);

    core_state_t state_reg, state_next;
    logic [63:0] h_reg [8];
    logic [63:0] v_reg [8];
    logic [63:0] w_reg [16];
    logic [63:0] blk_reg [16];
    logic [6:0]  fill_reg;
    logic [60:0] total_reg;
    logic [6:0]  round_reg;
    req_t        cur_reg;
    logic [3:0]  bi_reg;
    logic        pad_done_reg;
    logic        final_reg;
    logic [2:0]  oi_reg;

    logic        put_en;
    logic [7:0]  put_byte;
    logic [63:0] wt, s0, s1, t1, t2, wnew;
    logic [3:0]  slot;
    logic [63:0] bits;
    logic [63:0] merged;
    logic        round_start;
    logic        len_block;

    assign slot = round_reg[3:0];
    assign s1 = rotr(w_reg[slot - 4'd2], 19) ^ rotr(w_reg[slot - 4'd2], 61)
                ^ (w_reg[slot - 4'd2] >> 6);
    assign s0 = rotr(w_reg[slot - 4'd15], 1) ^ rotr(w_reg[slot - 4'd15], 8)
                ^ (w_reg[slot - 4'd15] >> 7);
    assign wnew = s1 + w_reg[slot - 4'd7] + s0 + w_reg[slot];
    assign wt = (round_reg >= 7'd16) ? wnew : w_reg[slot];
    assign t1 = v_reg[7] + (rotr(v_reg[4], 14) ^ rotr(v_reg[4], 18) ^ rotr(v_reg[4], 41))
                + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[round_reg] + wt;
    assign t2 = (rotr(v_reg[0], 28) ^ rotr(v_reg[0], 34) ^ rotr(v_reg[0], 39))
                + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign q_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = h_reg[oi_reg];
    assign word_index = oi_reg;
    assign digest_last = (oi_reg == 3'd7);

    assign round_start = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
    assign len_block = (state_reg == ST_PAD) && pad_done_reg && (fill_reg == 7'd112);

    // pick the byte to place this cycle: message, pad marker or zero fill
    always_comb
    begin
        put_en = 1'b0;
        put_byte = 8'h00;
        case (state_reg)
            ST_LOAD:
            begin
                put_en = 1'b1;
                put_byte = 8'(cur_reg.word >> (7'd56 - {bi_reg[2:0], 3'b000}));
            end
            ST_PAD:
            begin
                put_en = (fill_reg != 7'd112) || !pad_done_reg;
                put_byte = pad_done_reg ? 8'h00 : PAD_BYTE;
            end
            default: ;
        endcase
        bits = {56'd0, put_byte} << (6'd56 - {fill_reg[2:0], 3'b000});
        merged = (fill_reg[2:0] == 3'd0) ? bits : (blk_reg[fill_reg[6:3]] | bits);
    end

    // sequence bytes, rounds, fold and digest output
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    state_next = (q_data.nbytes != 4'd0) ? ST_LOAD : ST_PAD;
            ST_LOAD:
                if (fill_reg == 7'd127)
                    state_next = ST_ROUND;
                else if (bi_reg + 4'd1 == cur_reg.nbytes)
                    state_next = cur_reg.last ? ST_PAD : ST_IDLE;
            ST_PAD:
                if (pad_done_reg && fill_reg == 7'd112)
                    state_next = ST_ROUND;
                else if (fill_reg == 7'd127)
                    state_next = ST_ROUND;
            ST_ROUND:
                if (round_reg == 7'd80)
                    state_next = ST_FOLD;
            ST_FOLD:
                if (final_reg)
                    state_next = ST_EMIT;
                else if (bi_reg != cur_reg.nbytes)
                    state_next = ST_LOAD;
                else if (cur_reg.last)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            ST_EMIT:
                if (out_ready && oi_reg == 3'd7)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
                blk_reg[i] <= '0;
            end
            fill_reg <= '0;
            total_reg <= '0;
            round_reg <= '0;
            bi_reg <= '0;
            pad_done_reg <= 1'b0;
            final_reg <= 1'b0;
            oi_reg <= '0;
            cur_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // take a new request
            if (state_reg == ST_IDLE && q_valid)
            begin
                cur_reg <= q_data;
                bi_reg <= '0;
                pad_done_reg <= 1'b0;
            end
            // place one byte into the block
            if (put_en)
            begin
                blk_reg[fill_reg[6:3]] <= merged;
                if (state_reg == ST_LOAD)
                begin
                    bi_reg <= bi_reg + 4'd1;
                    if (total_reg != TOTAL_MAX)
                        total_reg <= total_reg + 61'd1;
                end
                else
                    pad_done_reg <= 1'b1;
            end
            // advance the fill count, restart it when the block goes to the rounds
            if (round_start)
                fill_reg <= '0;
            else if (put_en)
                fill_reg <= fill_reg + 7'd1;
            // insert length and start rounds when the block is ready
            if (round_start)
            begin
                round_reg <= '0;
                final_reg <= len_block;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
                for (int i = 0; i < 16; i++)
                begin
                    if (len_block && i == 14)
                        w_reg[i] <= '0;
                    else if (len_block && i == 15)
                        w_reg[i] <= {total_reg, 3'b000};
                    else if (put_en && 4'(i) == fill_reg[6:3])
                        w_reg[i] <= merged;
                    else
                        w_reg[i] <= blk_reg[i];
                end
            end
            // run one round
            if (state_reg == ST_ROUND && round_reg != 7'd80)
            begin
                w_reg[slot] <= wt;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 7'd1;
            end
            // fold the working set into the hash
            if (state_reg == ST_FOLD)
            begin
                round_reg <= '0;
                final_reg <= 1'b0;
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            // hand out digest words, then restore the initial hash
            if (state_reg == ST_EMIT && out_ready)
            begin
                oi_reg <= oi_reg + 3'd1;
                if (oi_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= INIT_H[i];
                    total_reg <= '0;
                end
            end
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sha512_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 3000000;

    // one directed request row: expected digest word 0 is given for known messages
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        has_known;
        logic [63:0] known_h0;
    } dir_row_t;

    typedef struct {
        logic [63:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] message_word;
    logic [3:0]  valid_bytes;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    // predictor state
    logic [63:0] hstate [8];
    logic [63:0] blk [16];
    int unsigned fill;
    logic [60:0] msg_bytes;

    digest_t     pending_digests[$];
    int unsigned mismatch_count = 0;
    int unsigned unexpected_count = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [63:0] known_first [$];

    dir_row_t    dir_rows [$];

    sha512_hash_engine_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .digest_last  (digest_last)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // run 80 rounds over the current block and fold into the hash state
    task automatic compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] t1;
        logic [63:0] t2;
        logic [63:0] s0;
        logic [63:0] s1;
        int slot;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = blk[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hstate[i];
        end
        for (int r = 0; r < 80; r++)
        begin
            slot = r & 15;
            if (r >= 16)
            begin
                s1 = ror64(w[(r - 2) & 15], 19) ^ ror64(w[(r - 2) & 15], 61)
                     ^ (w[(r - 2) & 15] >> 6);
                s0 = ror64(w[(r - 15) & 15], 1) ^ ror64(w[(r - 15) & 15], 8)
                     ^ (w[(r - 15) & 15] >> 7);
                w[slot] = s1 + w[(r - 7) & 15] + s0 + w[slot];
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + w[slot];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hstate[i] = hstate[i] + v[i];
        end
    endtask

    task automatic append_byte(logic [7:0] b);
        int wi;
        int sh;
        wi = fill >> 3;
        sh = 56 - 8 * (fill & 7);
        if ((fill & 7) == 0)
            blk[wi] = 64'(b) << sh;
        else
            blk[wi] = blk[wi] | (64'(b) << sh);
        fill++;
        if (fill >= 128)
        begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic reset_digest_model();
        for (int i = 0; i < 8; i++)
        begin
            hstate[i] = INIT_H[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            blk[i] = '0;
        end
        fill = 0;
        msg_bytes = '0;
    endtask

    // take one request into the predictor, queue the digest on a last word
    task automatic absorb_request(logic [63:0] w, logic [3:0] nb, logic lst);
        int n;
        digest_t d;
        n = (nb > 8) ? 8 : nb;
        for (int i = 0; i < n; i++)
        begin
            append_byte(w[63 - 8 * i -: 8]);
            if (msg_bytes != TOTAL_MAX)
                msg_bytes++;
        end
        if (lst)
        begin
            append_byte(PAD_BYTE);
            while (fill != 112)
            begin
                append_byte(8'h00);
            end
            blk[14] = 64'(msg_bytes >> 61);
            blk[15] = {msg_bytes[60:0], 3'b000};
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.word = hstate[i];
                d.idx  = 3'(i);
                d.last = (i == 7);
                pending_digests.push_back(d);
            end
            for (int i = 0; i < 8; i++)
            begin
                hstate[i] = INIT_H[i];
            end
            fill = 0;
            msg_bytes = '0;
        end
    endtask

    // drive one request and hold it until accepted
    task automatic send_request(logic [63:0] w, logic [3:0] nb, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        valid_bytes  <= nb;
        last         <= lst;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        absorb_request(w, nb, lst);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_digests.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // random message: mostly full words, random lengths, sometimes noise
    task automatic send_random_message(int max_words);
        int nw;
        logic [3:0] nb;
        nw = $urandom_range(max_words);
        for (int i = 0; i < nw; i++)
        begin
            nb = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
            send_request({$urandom, $urandom}, nb, 1'b0);
        end
        send_request({$urandom, $urandom}, 4'($urandom_range(15)), 1'b1);
    endtask

    // sink: random stall, compare each digest word in order
    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        digest_t exp_d;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digests.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected digest word %h idx %0d", digest_word, word_index);
            end
            else
            begin
                exp_d = pending_digests.pop_front();
                if (digest_word !== exp_d.word || word_index !== exp_d.idx
                    || digest_last !== exp_d.last)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_d.word, exp_d.idx, exp_d.last,
                                 digest_word, word_index, digest_last);
                end
                if (exp_d.idx == 3'd0 && known_first.size() != 0)
                begin
                    // check against a published digest where one is known
                    if (known_first[0] !== 64'h0 && digest_word !== known_first[0])
                    begin
                        mismatch_count++;
                        if (mismatch_count + unexpected_count <= 10)
                            $display("known digest mismatch: exp %h got %h",
                                     known_first[0], digest_word);
                    end
                    void'(known_first.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        dir_row_t r;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        message_word = '0;
        valid_bytes = '0;
        last = 1'b0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reset_digest_model();

        // empty message and "abc" have published digests
        dir_rows.push_back('{64'h0, 4'd0, 1'b1, 1'b1, 64'hcf83e1357eefb8bd});
        dir_rows.push_back('{64'h6162_6300_0000_0000, 4'd3, 1'b1, 1'b1,
                             64'hddaf35a193617aba});
        // garbage below the valid bytes, empty non-last word, oversize count
        dir_rows.push_back('{64'h6162_63ff_ffff_ffff, 4'd0, 1'b0, 1'b0, 64'h0});
        dir_rows.push_back('{64'h6162_63ff_ffff_ffff, 4'd3, 1'b1, 1'b1,
                             64'hddaf35a193617aba});
        dir_rows.push_back('{64'hffff_ffff_ffff_ffff, 4'd15, 1'b0, 1'b0, 64'h0});
        dir_rows.push_back('{64'h0, 4'd8, 1'b0, 1'b0, 64'h0});
        dir_rows.push_back('{64'h0123_4567_89ab_cdef, 4'd9, 1'b1, 1'b0, 64'h0});
        // 15 full words then a last word: padding spills into a second block
        for (int i = 0; i < 15; i++)
        begin
            dir_rows.push_back('{~(64'(i) * 64'h1111_1111_1111_1111), 4'd8, 1'b0,
                                 1'b0, 64'h0});
        end
        dir_rows.push_back('{64'hfedc_ba98_7654_3210, 4'd7, 1'b1, 1'b0, 64'h0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.last)
                known_first.push_back(r.has_known ? r.known_h0 : 64'h0);
            send_request(r.word, r.nbytes, r.last);
        end
        wait_drained();

        // random messages over the idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 86 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 86 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 7;
                recv_stall_pct = 7;
            end
            for (int m = 0; m < 5; m++)
            begin
                send_random_message((m == 4) ? 20 : 6);
            end
            // hold off the sender until every digest word is out
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && unexpected_count == 0 && pending_digests.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
